FILE: rtl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int NUM_PAGES = 4096;
  localparam int TOP_ORDER = 10;
  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = PW + 1;
  localparam int OW = 4;
  localparam int CW = 13;
  localparam int NL = TOP_ORDER + 1;
  localparam logic [LW-1:0] LINK_NONE = LW'(NUM_PAGES);
  localparam logic [CW-1:0] COUNT_MAX = '1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BIG = 2'd1;
  localparam logic [1:0] ST_NOBLK = 2'd2;

  typedef struct packed {
    logic          kind;
    logic [OW-1:0] order;
    logic [PW-1:0] page;
  } req_t;

  typedef struct packed {
    logic          granted;
    logic [PW-1:0] block_page;
    logic [1:0]    status;
    logic [CW-1:0] free_total;
  } rsp_t;
endpackage

FILE: rtl/bpa_front.sv
// Request front end: two-entry request queue.
`timescale 1ns / 1ps
module bpa_front import bpa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic [OW-1:0] in_order,
  input  logic [PW-1:0] in_page_index,
  output logic          q_valid,
  output req_t          q_req,
  input  logic          q_take
);
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = mem_r[rp_r];

  // Store accepted transactions
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{kind: in_kind, order: in_order, page: in_page_index};
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

FILE: rtl/bpa_back.sv
// Execution engine: free lists, split and merge sequencer, result register.
`timescale 1ns / 1ps
module bpa_back import bpa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  req_t          q_req,
  output logic          q_take,
  output logic          out_valid,
  input  logic          out_stall,
  output rsp_t          out_rsp,
  output logic          busy
);
  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_DEC, S_ARD, S_SPLIT, S_FCHK, S_FPUSH, S_MCHK, S_MRD,
    S_MREM_B, S_MREM_P, S_RM0, S_RM1, S_RM2, S_PU0, S_PU1, S_DONE
  } state_t;

  // Per-page stores; valid bits cleared by a sweep
  logic          fl_mem [NUM_PAGES];
  logic [OW-1:0] ord_mem [NUM_PAGES];
  logic [LW-1:0] nx_mem [NUM_PAGES];
  logic [LW-1:0] pv_mem [NUM_PAGES];
  logic [LW-1:0] head_r [NL];

  state_t        st_r, ret_r;
  logic [PW:0]   clr_r;
  req_t          req_r;
  logic [OW-1:0] i_r, o_r;
  logic [PW-1:0] p_r, tgt_r;
  logic [CW-1:0] cnt_r;
  logic          fl_rd_r;
  logic [OW-1:0] ord_rd_r;
  logic [LW-1:0] nx_rd_r, pv_rd_r;
  logic [PW-1:0] rd_addr;
  logic          ov_r;
  rsp_t          wrk_r;
  rsp_t          rsp_r;

  // Build a full response word
  function automatic rsp_t rsp_pack(logic g, logic [PW-1:0] bp, logic [1:0] s,
                                    logic [CW-1:0] ft);
    rsp_pack = '{granted: g, block_page: bp, status: s, free_total: ft};
  endfunction

  // Free count arithmetic
  logic [PW:0]   sz;
  logic [CW:0]   sum;
  logic [PW:0]   endp;
  logic [PW-1:0] bud;
  logic [CW-1:0] cnt_dec;
  assign sz = (PW+1)'(1) << req_r.order;
  assign sum = {1'b0, cnt_r} + (CW+1)'(sz);
  assign endp = {1'b0, req_r.page} + sz;
  assign bud = p_r ^ (PW'(1) << o_r);
  assign cnt_dec = ({1'b0, cnt_r} > (CW+1)'(sz)) ? cnt_r - CW'(sz) : '0;

  assign q_take = (st_r == S_IDLE) && q_valid && !(out_valid && out_stall) ;
  assign out_valid = ov_r;
  assign out_rsp = rsp_r;
  assign busy = (st_r != S_IDLE);

  // Lowest non-empty order at or above the request
  logic [OW-1:0] fnd;
  logic          fnd_ok;
  always_comb begin
    fnd = '0;
    fnd_ok = 1'b0;
    for (int k = NL - 1; k >= 0; k--) begin
      if (k >= int'(req_r.order) && head_r[k] != LINK_NONE) begin
        fnd = OW'(k);
        fnd_ok = 1'b1;
      end
    end
  end

  always_comb begin
    rd_addr = tgt_r;
  end

  // Registered memory read
  always_ff @(posedge clk) begin
    fl_rd_r <= fl_mem[rd_addr];
    ord_rd_r <= ord_mem[rd_addr];
    nx_rd_r <= nx_mem[rd_addr];
    pv_rd_r <= pv_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
      for (int k = 0; k < NL; k++) head_r[k] <= LINK_NONE;
    end else begin
      // Raise valid when a result registers, drop it once taken
      if (st_r == S_DONE && !(ov_r && out_stall)) ov_r <= 1'b1;
      else if (out_valid && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          fl_mem[clr_r[PW-1:0]] <= 1'b0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == (PW+1)'(NUM_PAGES - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_take) begin
            req_r <= q_req;
            tgt_r <= q_req.page;
            st_r <= S_DEC;
          end
        end
        S_DEC: begin
          if (!req_r.kind) begin
            if (req_r.order >= OW'(TOP_ORDER)) begin
              wrk_r <= rsp_pack(1'b0, '0, ST_BIG, cnt_r); st_r <= S_DONE;
            end else if (!fnd_ok) begin
              wrk_r <= rsp_pack(1'b0, '0, ST_NOBLK, cnt_r); st_r <= S_DONE;
            end else begin
              i_r <= fnd;
              p_r <= head_r[fnd][PW-1:0];
              tgt_r <= head_r[fnd][PW-1:0];
              ret_r <= S_SPLIT;
              st_r <= S_RM0;
            end
          end else begin
            if (req_r.order > OW'(TOP_ORDER)) begin
              wrk_r <= rsp_pack(1'b0, '0, ST_BIG, cnt_r); st_r <= S_DONE;
            end else st_r <= S_FCHK;
          end
        end
        S_FCHK: begin
          if ((req_r.page & PW'(sz - 1'b1)) != '0 || endp > (PW+1)'(NUM_PAGES)
              || fl_rd_r) begin
            wrk_r <= rsp_pack(1'b0, '0, ST_NOBLK, cnt_r); st_r <= S_DONE;
          end else begin
            cnt_r <= (sum > (CW+1)'(COUNT_MAX)) ? COUNT_MAX : sum[CW-1:0];
            o_r <= req_r.order;
            p_r <= req_r.page;
            tgt_r <= req_r.page;
            ret_r <= S_MCHK;
            st_r <= S_PU0;
          end
        end
        // Remove block at tgt_r: wait for read, then unlink
        S_RM0: st_r <= S_RM1;
        S_RM1: begin
          fl_mem[tgt_r] <= 1'b0;
          if (pv_rd_r != LINK_NONE) nx_mem[pv_rd_r[PW-1:0]] <= nx_rd_r;
          else head_r[(ord_rd_r > OW'(TOP_ORDER)) ? OW'(TOP_ORDER) : ord_rd_r]
                 <= nx_rd_r;
          st_r <= S_RM2;
        end
        S_RM2: begin
          if (nx_rd_r != LINK_NONE) pv_mem[nx_rd_r[PW-1:0]] <= pv_rd_r;
          st_r <= ret_r;
        end
        // Push tgt_r onto list o_r
        S_PU0: begin
          nx_mem[tgt_r] <= head_r[o_r];
          pv_mem[tgt_r] <= LINK_NONE;
          ord_mem[tgt_r] <= o_r;
          fl_mem[tgt_r] <= 1'b1;
          if (head_r[o_r] != LINK_NONE) pv_mem[head_r[o_r][PW-1:0]] <= {1'b0, tgt_r};
          head_r[o_r] <= {1'b0, tgt_r};
          st_r <= ret_r;
        end
        S_SPLIT: begin
          if (i_r > req_r.order) begin
            i_r <= i_r - 1'b1;
            o_r <= i_r - 1'b1;
            tgt_r <= p_r | (PW'(1) << (i_r - 1'b1));
            ret_r <= S_SPLIT;
            st_r <= S_PU0;
          end else begin
            cnt_r <= cnt_dec;
            wrk_r <= rsp_pack(1'b1, p_r, ST_OK, cnt_dec);
            st_r <= S_DONE;
          end
        end
        S_MCHK: begin
          if (o_r >= OW'(TOP_ORDER) || {1'b0, bud} >= LW'(NUM_PAGES)) begin
            wrk_r <= rsp_pack(1'b1, '0, ST_OK, cnt_r); st_r <= S_DONE;
          end else begin
            tgt_r <= bud; st_r <= S_MRD;
          end
        end
        S_MRD: st_r <= S_ARD;
        S_ARD: begin
          if (!fl_rd_r || ord_rd_r != o_r) begin
            wrk_r <= rsp_pack(1'b1, '0, ST_OK, cnt_r); st_r <= S_DONE;
          end else begin
            ret_r <= S_MREM_B; st_r <= S_RM1;
          end
        end
        S_MREM_B: begin
          tgt_r <= p_r; ret_r <= S_MREM_P; st_r <= S_RM0;
        end
        S_MREM_P: begin
          p_r <= p_r & ~(PW'(1) << o_r);
          tgt_r <= p_r & ~(PW'(1) << o_r);
          o_r <= o_r + 1'b1;
          ret_r <= S_MCHK;
          st_r <= S_PU0;
        end
        // Hand the finished response to the output register once it is free
        S_DONE: begin
          if (!(ov_r && out_stall)) begin
            rsp_r <= wrk_r; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator.
`timescale 1ns / 1ps
// An allocate takes a block from the lowest non-empty order that fits and splits it down
// to the requested order; a free pushes the block and merges it with its free buddy,
// order by order, up to the top order. Oversize orders, an empty pool and frees refused by
// the block checks are answered without list changes. One request is worked at a time; the
// next queued one is taken once the engine is idle and the output not stalled. Reset:
// synchronous; a clearing pass sweeps all 4096 free flags; requests queue (two deep) but wait.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic [OW-1:0] in_order,
  input  logic [PW-1:0] in_page_index,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_granted,
  output logic [PW-1:0] out_block_page,
  output logic [1:0]    out_status,
  output logic [CW-1:0] out_free_total
);
  logic q_valid, q_take, busy;
  req_t q_req;
  rsp_t rsp;

  bpa_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_order,
    .in_page_index, .q_valid, .q_req, .q_take);
  bpa_back u_back (.clk, .rst_n, .q_valid, .q_req, .q_take, .out_valid, .out_stall,
    .out_rsp(rsp), .busy);

  assign out_granted = rsp.granted;
  assign out_block_page = rsp.block_page;
  assign out_status = rsp.status;
  assign out_free_total = rsp.free_total;

  // A granted result always reports ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_status == ST_OK) else $error("grant with bad status");
  // The engine takes no request while busy
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !busy) else $error("take while busy");
  // Refused requests carry no block page
  a_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_block_page == '0) else $error("page on refusal");
endmodule
